>>> hdl/mtcs_pkg.sv
// shared types and constants for the topic count sampler
package mtcs_pkg;

   localparam int KIND_W   = 3;
   localparam int WORD_W   = 10;
   localparam int DOC_W    = 8;
   localparam int TOPIC_W  = 6;
   localparam int WEIGHT_W = 24;
   localparam int TOKEN_W  = 16;
   localparam int DRAW_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 32;
   localparam int CSR_W    = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [KIND_W-1:0] KIND_WR_WORD  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WR_DOC   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_OPEN     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DRAW     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RD_DOC   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_RD_WORD  = 3'd5;

   localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TOPICS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WORDS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DOCS   = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [WORD_W-1:0]   word;
      logic [DOC_W-1:0]    doc;
      logic [TOPIC_W-1:0]  topic;
      logic [WEIGHT_W-1:0] weight;
      logic [TOKEN_W-1:0]  token_count;
      logic [DRAW_W-1:0]   random_draw;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TOPIC_W-1:0]  chosen_topic;
      logic [COUNT_W-1:0]  count_value;
      logic [TOKEN_W-1:0]  tokens_left;
   } rsp_type;

endpackage

>>> hdl/multinomial_topic_count_sampler.sv
// top level: topic count sampler with weight, sum and count memories
// Usage: configuration writes go through csr_we / csr_index / csr_wdata while idle.
// A transaction is taken on start high while busy is low; busy stays high until
// the single result is shown on rsp_valid / rsp_data for one cycle. The receiver
// cannot stall, so the result is simply dropped if not captured. busy is low in
// the cycle the result is shown, so the next transaction can be taken then.
// Steps per transaction:
//   weight writes, bad indices, undefined kinds: decode, then the result
//   count reads: decode, one memory read, then the result
//   open cell: the same length whatever topics_in_use is; the walk covers
//     every sums entry, one weight pair read and one multiply-accumulate per topic
//   draw with tokens left: fetch the total and form the threshold, then a binary
//     search over the sums memory, then a read-modify-write of both count memories
// After reset the count memories are cleared by a sweep over every word-topic
// address during which busy is high; the sums memory is cleared in the same pass.
module multinomial_topic_count_sampler #(
   parameter int MAX_TOPICS = 64,
   parameter int MAX_WORDS  = 1024,
   parameter int MAX_DOCS   = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  mtcs_pkg::req_type     req_data,
   output logic                  rsp_valid,
   output mtcs_pkg::rsp_type     rsp_data,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [10:0]           csr_wdata
);
   import mtcs_pkg::*;

   localparam int TW  = $clog2(MAX_TOPICS);
   localparam int WW  = $clog2(MAX_WORDS);
   localparam int DW  = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
   localparam int WTD = MAX_WORDS * MAX_TOPICS;
   localparam int DTD = MAX_DOCS * MAX_TOPICS;
   localparam int WTA = $clog2(WTD);
   localparam int DTA = $clog2(DTD);
   localparam int SUM_W = 2 * WEIGHT_W + TW;
   localparam int CLR_W = WTA + 1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD, S_RDW, S_OPEN, S_OPEN_END, S_TOT, S_MUL, S_SRCH,
      S_SRCHW, S_CNT, S_CNTW, S_DONE
   } state_type;

   state_type state_ff;
   req_type   req_ff;
   rsp_type   rsp_ff;
   logic      rsp_valid_ff;

   logic [TW:0]          nt_ff;
   logic [WW:0]          nw_ff;
   logic [DW:0]          nd_ff;
   logic [WORD_W-1:0]    open_word_ff;
   logic [DOC_W-1:0]     open_doc_ff;
   logic [TOKEN_W-1:0]   remaining_ff;
   logic [CLR_W-1:0]     clr_ff;

   // memories
   logic [WEIGHT_W-1:0] wtw_mem [WTD];
   logic [WEIGHT_W-1:0] tdw_mem [DTD];
   logic [SUM_W-1:0]    sum_mem [MAX_TOPICS];
   logic [COUNT_W-1:0]  dtc_mem [DTD];
   logic [COUNT_W-1:0]  wtc_mem [WTD];
   logic [WEIGHT_W-1:0] wtw_q, tdw_q;
   logic [SUM_W-1:0]    sum_q;
   logic [COUNT_W-1:0]  dtc_q, wtc_q;

   logic [WTA-1:0] wtw_ra, wtc_ra;
   logic [DTA-1:0] tdw_ra, dtc_ra;
   logic [TW-1:0]  sum_ra;
   logic           wtw_we, tdw_we, sum_we, dtc_we, wtc_we;
   logic [WTA-1:0] wtw_wa, wtc_wa;
   logic [DTA-1:0] tdw_wa, dtc_wa;
   logic [TW-1:0]  sum_wa;
   logic [SUM_W-1:0] sum_wd;
   logic [COUNT_W-1:0] dtc_wd, wtc_wd;

   // walk / search registers
   logic [TW:0]        k_ff;
   logic [TW:0]        kd_ff;
   logic               kv_ff;
   logic [SUM_W-1:0]   acc_ff;
   logic [2*WEIGHT_W-1:0] prod_ff;
   logic               pv_ff;
   logic [SUM_W-1:0]   total_ff;
   logic [SUM_W-1:0]   thr_ff;
   logic [SUM_W+DRAW_W-1:0] phi_ff, plo_ff;
   logic [TW:0]        lo_ff, hi_ff, mid_ff;
   logic [1:0]         mstep_ff;

   // effective sizes
   logic [TW:0] nt;
   logic [WW:0] nw;
   logic [DW:0] nd;
   logic        word_ok, doc_ok, topic_ok;
   assign nt = nt_ff;
   assign nw = nw_ff;
   assign nd = nd_ff;
   assign word_ok  = {{(32-WORD_W){1'b0}}, req_ff.word}   < 32'(nw);
   assign doc_ok   = {{(32-DOC_W){1'b0}}, req_ff.doc}     < 32'(nd);
   assign topic_ok = {{(32-TOPIC_W){1'b0}}, req_ff.topic} < 32'(nt);

   function automatic logic [31:0] clamp(input logic [31:0] v, input int mx);
      logic [31:0] r;
      r = v;
      if (v == 32'd0) r = 32'd1;
      else if (v > 32'(mx)) r = 32'(mx);
      return r;
   endfunction

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // memory port logic
   always_ff @(posedge clock) begin
      if (wtw_we) wtw_mem[wtw_wa] <= req_ff.weight;
      wtw_q <= wtw_mem[wtw_ra];
   end
   always_ff @(posedge clock) begin
      if (tdw_we) tdw_mem[tdw_wa] <= req_ff.weight;
      tdw_q <= tdw_mem[tdw_ra];
   end
   always_ff @(posedge clock) begin
      if (sum_we) sum_mem[sum_wa] <= sum_wd;
      sum_q <= sum_mem[sum_ra];
   end
   always_ff @(posedge clock) begin
      if (dtc_we) dtc_mem[dtc_wa] <= dtc_wd;
      dtc_q <= dtc_mem[dtc_ra];
   end
   always_ff @(posedge clock) begin
      if (wtc_we) wtc_mem[wtc_wa] <= wtc_wd;
      wtc_q <= wtc_mem[wtc_ra];
   end

   logic [TW-1:0]  kt;
   logic [TW-1:0]  chosen;
   logic [SUM_W-1:0] acc_next;
   // the walk always starts with topic 0 fetched during decode
   assign kt = (state_ff == S_RD) ? '0 : k_ff[TW-1:0];
   assign chosen = lo_ff[TW-1:0];
   assign acc_next = acc_ff + SUM_W'(prod_ff);

   // addresses and writes
   always_comb begin
      wtw_we = 1'b0; tdw_we = 1'b0; sum_we = 1'b0; dtc_we = 1'b0; wtc_we = 1'b0;
      wtw_wa = WTA'({req_ff.word, req_ff.topic});
      wtw_wa = WTA'(32'(req_ff.word) * MAX_TOPICS + 32'(req_ff.topic));
      tdw_wa = DTA'(32'(req_ff.topic) * MAX_DOCS + 32'(req_ff.doc));
      wtw_ra = WTA'(32'(req_ff.word) * MAX_TOPICS + 32'(kt));
      tdw_ra = DTA'(32'(kt) * MAX_DOCS + 32'(req_ff.doc));
      sum_wa = kd_ff[TW-1:0];
      sum_wd = acc_next;
      sum_ra = mid_ff[TW-1:0];
      dtc_ra = DTA'(32'(req_ff.doc) * MAX_TOPICS + 32'(req_ff.topic));
      wtc_ra = WTA'(32'(req_ff.word) * MAX_TOPICS + 32'(req_ff.topic));
      dtc_wa = DTA'(32'(open_doc_ff) * MAX_TOPICS + 32'(chosen));
      wtc_wa = WTA'(32'(open_word_ff) * MAX_TOPICS + 32'(chosen));
      dtc_wd = (dtc_q == '1) ? dtc_q : dtc_q + COUNT_W'(1);
      wtc_wd = (wtc_q == '1) ? wtc_q : wtc_q + COUNT_W'(1);
      case (state_ff)
         S_CLEAR: begin
            dtc_wa = DTA'(clr_ff); wtc_wa = WTA'(clr_ff); sum_wa = TW'(clr_ff);
            dtc_wd = '0; wtc_wd = '0; sum_wd = '0;
            dtc_we = 32'(clr_ff) < DTD; wtc_we = 1'b1; sum_we = 32'(clr_ff) < MAX_TOPICS;
         end
         S_RD: begin
            wtw_we = (req_ff.kind == KIND_WR_WORD) && word_ok && topic_ok;
            tdw_we = (req_ff.kind == KIND_WR_DOC) && doc_ok && topic_ok;
         end
         S_OPEN, S_OPEN_END: sum_we = pv_ff;
         S_TOT: sum_ra = TW'(nt - 1'b1);
         S_CNT: begin
            dtc_ra = dtc_wa; wtc_ra = wtc_wa;
         end
         S_CNTW: begin
            dtc_we = 1'b1; wtc_we = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         nt_ff <= (TW+1)'(clamp(32'd64, MAX_TOPICS));
         nw_ff <= (WW+1)'(clamp(32'd1024, MAX_WORDS));
         nd_ff <= (DW+1)'(clamp(32'd256, MAX_DOCS));
         open_word_ff <= '0;
         open_doc_ff <= '0;
         remaining_ff <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_TOPICS: nt_ff <= (TW+1)'(clamp(32'(csr_wdata[6:0]), MAX_TOPICS));
               CSR_WORDS:  nw_ff <= (WW+1)'(clamp(32'(csr_wdata), MAX_WORDS));
               CSR_DOCS:   nd_ff <= (DW+1)'(clamp(32'(csr_wdata[8:0]), MAX_DOCS));
               default: ;
            endcase
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (32'(clr_ff) == WTD - 1) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (start) begin
                  req_ff <= req_data;
                  state_ff <= S_RD;
               end
            end
            S_RD: begin
               rsp_ff <= '0;
               rsp_ff.tokens_left <= remaining_ff;
               k_ff <= '0; kv_ff <= 1'b0; pv_ff <= 1'b0; acc_ff <= '0;
               state_ff <= S_DONE;
               case (req_ff.kind)
                  KIND_WR_WORD: if (!(word_ok && topic_ok)) rsp_ff.status <= ST_RANGE;
                  KIND_WR_DOC:  if (!(doc_ok && topic_ok)) rsp_ff.status <= ST_RANGE;
                  KIND_OPEN: begin
                     if (word_ok && doc_ok) begin
                        state_ff <= S_OPEN;
                        kv_ff <= 1'b1;
                        k_ff <= (TW+1)'(1);
                        kd_ff <= '0;
                     end else rsp_ff.status <= ST_RANGE;
                  end
                  KIND_DRAW: begin
                     if (remaining_ff == '0) rsp_ff.status <= ST_EMPTY;
                     else state_ff <= S_TOT;
                  end
                  KIND_RD_DOC:
                     if (doc_ok && topic_ok) state_ff <= S_RDW;
                     else rsp_ff.status <= ST_RANGE;
                  KIND_RD_WORD:
                     if (word_ok && topic_ok) state_ff <= S_RDW;
                     else rsp_ff.status <= ST_RANGE;
                  default: ;
               endcase
            end
            S_RDW: begin
               rsp_ff.count_value <= (req_ff.kind == KIND_RD_DOC) ? dtc_q : wtc_q;
               state_ff <= S_DONE;
            end
            S_OPEN: begin
               // weights for topic k-1 arrive now, the product for kd is summed; k runs one ahead
               if (pv_ff) acc_ff <= acc_next;
               prod_ff <= kv_ff ? wtw_q * tdw_q : '0;
               pv_ff <= 1'b1;
               if (pv_ff) kd_ff <= kd_ff + 1'b1;
               if (k_ff < nt) k_ff <= k_ff + 1'b1;
               else kv_ff <= 1'b0;
               if (pv_ff && 32'(kd_ff) == MAX_TOPICS - 2) state_ff <= S_OPEN_END;
            end
            S_OPEN_END: begin
               open_word_ff <= req_ff.word;
               open_doc_ff <= req_ff.doc;
               remaining_ff <= req_ff.token_count;
               rsp_ff.tokens_left <= req_ff.token_count;
               state_ff <= S_DONE;
            end
            S_TOT: begin
               mstep_ff <= '0;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               mstep_ff <= mstep_ff + 1'b1;
               if (mstep_ff == 2'd0) begin
                  total_ff <= sum_q;
               end else if (mstep_ff == 2'd1) begin
                  phi_ff <= (SUM_W+DRAW_W)'(total_ff[SUM_W-1:32] * req_ff.random_draw);
                  plo_ff <= (SUM_W+DRAW_W)'(total_ff[31:0] * req_ff.random_draw);
               end else begin
                  thr_ff <= SUM_W'(phi_ff + (plo_ff >> 32));
                  lo_ff <= '0;
                  hi_ff <= nt - 1'b1;
                  mid_ff <= (nt - 1'b1) >> 1;
                  state_ff <= S_SRCH;
               end
            end
            S_SRCH: begin
               // sums read at mid lands next cycle
               if (lo_ff == hi_ff) state_ff <= S_CNT;
               else state_ff <= S_SRCHW;
            end
            S_SRCHW: begin
               if (sum_q >= thr_ff) begin
                  hi_ff <= mid_ff;
                  mid_ff <= (lo_ff + mid_ff) >> 1;
               end else begin
                  lo_ff <= mid_ff + 1'b1;
                  mid_ff <= (mid_ff + 1'b1 + hi_ff) >> 1;
               end
               state_ff <= S_SRCH;
            end
            S_CNT: state_ff <= S_CNTW;
            S_CNTW: begin
               remaining_ff <= remaining_ff - 1'b1;
               rsp_ff.tokens_left <= remaining_ff - 1'b1;
               rsp_ff.chosen_topic <= TOPIC_W'(chosen);
               state_ff <= S_DONE;
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

>>> tb/sv/tb_multinomial_topic_count_sampler.sv
// self-checking testbench for the multinomial topic count sampler
`timescale 1ns / 100ps

module tb_multinomial_topic_count_sampler;
   import mtcs_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNDEF_LO = 3'd6;
   localparam logic [KIND_W-1:0] KIND_UNDEF_HI = 3'd7;
   localparam int NTOPIC = 64;
   localparam int NWORD  = 1024;
   localparam int NDOC   = 256;
   localparam int STALL_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 90;

   class topic_count_predictor;
      logic [WEIGHT_W-1:0] word_weight [NWORD*NTOPIC];
      bit                  word_weight_set [NWORD*NTOPIC];
      logic [WEIGHT_W-1:0] doc_weight [NTOPIC*NDOC];
      bit                  doc_weight_set [NTOPIC*NDOC];
      bit [53:0]           run_sum [NTOPIC];
      bit [COUNT_W-1:0]    doc_count [NDOC*NTOPIC];
      bit [COUNT_W-1:0]    word_count [NWORD*NTOPIC];
      bit [WORD_W-1:0]     cell_word;
      bit [DOC_W-1:0]      cell_doc;
      bit [TOKEN_W-1:0]    tokens_rem;
      bit [6:0]            reg_topics;
      bit [10:0]           reg_words;
      bit [8:0]            reg_docs;
      rsp_type             expected_rsp [$];
      int                  errors;

      function new();
         reg_topics = 7'd64;
         reg_words  = 11'd1024;
         reg_docs   = 9'd256;
         errors     = 0;
      endfunction

      function int clamp(int v, int maxv);
         if (v < 1) return 1;
         if (v > maxv) return maxv;
         return v;
      endfunction

      function int topics_eff();
         return clamp(reg_topics, NTOPIC);
      endfunction

      function int words_eff();
         return clamp(reg_words, NWORD);
      endfunction

      function int docs_eff();
         return clamp(reg_docs, NDOC);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         case (idx)
            CSR_TOPICS: reg_topics = val[6:0];
            CSR_WORDS:  reg_words  = val[10:0];
            CSR_DOCS:   reg_docs   = val[8:0];
            default: ;
         endcase
      endfunction

      function void note_request(req_type r);
         rsp_type   e;
         int        nt, nw, nd, k, wi, di;
         bit        word_ok, doc_ok, topic_ok;
         bit [53:0] acc;
         bit [85:0] prod;
         bit [53:0] thr;
         nt = topics_eff();
         nw = words_eff();
         nd = docs_eff();
         word_ok  = r.word < nw;
         doc_ok   = r.doc < nd;
         topic_ok = r.topic < nt;
         e = '0;
         case (r.kind)
            KIND_WR_WORD: begin
               if (word_ok && topic_ok) begin
                  word_weight[r.word*NTOPIC + r.topic] = r.weight;
                  word_weight_set[r.word*NTOPIC + r.topic] = 1;
               end else e.status = ST_RANGE;
            end
            KIND_WR_DOC: begin
               if (doc_ok && topic_ok) begin
                  doc_weight[r.topic*NDOC + r.doc] = r.weight;
                  doc_weight_set[r.topic*NDOC + r.doc] = 1;
               end else e.status = ST_RANGE;
            end
            KIND_OPEN: begin
               if (word_ok && doc_ok) begin
                  acc = 0;
                  for (k = 0; k < NTOPIC; k++) begin
                     if (k < nt)
                        acc += 54'(word_weight[r.word*NTOPIC + k]) *
                               54'(doc_weight[k*NDOC + r.doc]);
                     run_sum[k] = acc;
                  end
                  cell_word  = r.word;
                  cell_doc   = r.doc;
                  tokens_rem = r.token_count;
               end else e.status = ST_RANGE;
            end
            KIND_DRAW: begin
               if (tokens_rem == 0) e.status = ST_EMPTY;
               else begin
                  prod = 86'(run_sum[nt-1]) * 86'(r.random_draw);
                  thr  = prod[85:32];
                  wi   = nt - 1;
                  for (k = nt - 1; k >= 0; k--)
                     if (run_sum[k] >= thr) wi = k;
                  di = cell_doc*NTOPIC + wi;
                  if (doc_count[di] != '1) doc_count[di]++;
                  if (word_count[cell_word*NTOPIC + wi] != '1)
                     word_count[cell_word*NTOPIC + wi]++;
                  tokens_rem--;
                  e.chosen_topic = TOPIC_W'(wi);
               end
            end
            KIND_RD_DOC: begin
               if (doc_ok && topic_ok) e.count_value = doc_count[r.doc*NTOPIC + r.topic];
               else e.status = ST_RANGE;
            end
            KIND_RD_WORD: begin
               if (word_ok && topic_ok) e.count_value = word_count[r.word*NTOPIC + r.topic];
               else e.status = ST_RANGE;
            end
            default: ;
         endcase
         e.tokens_left = tokens_rem;
         expected_rsp.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (expected_rsp.size() == 0) begin
            $error("result with no transaction outstanding: %h", got);
            errors++;
            return;
         end
         e = expected_rsp.pop_front();
         if (got.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, got.status);
            errors++;
         end
         if (got.chosen_topic !== e.chosen_topic) begin
            $error("chosen_topic expected %0d actual %0d", e.chosen_topic, got.chosen_topic);
            errors++;
         end
         if (got.count_value !== e.count_value) begin
            $error("count_value expected %0d actual %0d", e.count_value, got.count_value);
            errors++;
         end
         if (got.tokens_left !== e.tokens_left) begin
            $error("tokens_left expected %0d actual %0d", e.tokens_left, got.tokens_left);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_we;
   logic [1:0]  csr_index;
   logic [10:0] csr_wdata;

   topic_count_predictor sampler_model;
   bit calm;
   int quiet_cycles = 0;
   int sent_total = 0;

   multinomial_topic_count_sampler dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sampler_model.check_response(rsp_data);
   end

   // watchdog: no transaction moving in either direction
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("tb_multinomial_topic_count_sampler failed");
         $finish;
      end
   end

   function automatic req_type any_req(logic [KIND_W-1:0] kind);
      req_type r;
      r.kind        = kind;
      r.word        = WORD_W'($urandom);
      r.doc         = DOC_W'($urandom);
      r.topic       = TOPIC_W'($urandom);
      r.weight      = WEIGHT_W'($urandom);
      r.token_count = TOKEN_W'($urandom);
      r.random_draw = $urandom;
      return r;
   endfunction

   task automatic send(req_type r);
      if (!calm && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sampler_model.note_request(r);
      sent_total++;
   endtask

   task automatic settle();
      start <= 1'b0;
      while (sampler_model.expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [10:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sampler_model.write_reg(idx, val);
   endtask

   task automatic set_sizes(int t, int w, int d);
      settle();
      csr_write(CSR_TOPICS, 11'(t));
      csr_write(CSR_WORDS, 11'(w));
      csr_write(CSR_DOCS, 11'(d));
   endtask

   task automatic load_weight(logic [KIND_W-1:0] kind, int w, int d, int t, int val);
      req_type r;
      r = any_req(kind);
      r.word   = WORD_W'(w);
      r.doc    = DOC_W'(d);
      r.topic  = TOPIC_W'(t);
      r.weight = WEIGHT_W'(val);
      send(r);
   endtask

   // writes any weight the cell would read that has never been written
   task automatic fill_cell_weights(int w, int d);
      int k;
      for (k = 0; k < sampler_model.topics_eff(); k++) begin
         if (!sampler_model.word_weight_set[w*NTOPIC + k])
            load_weight(KIND_WR_WORD, w, d, k, $urandom_range(0, 3) == 0 ?
                        $urandom_range(0, 255) : $urandom);
         if (!sampler_model.doc_weight_set[k*NDOC + d])
            load_weight(KIND_WR_DOC, w, d, k, $urandom_range(0, 3) == 0 ?
                        $urandom_range(0, 255) : $urandom);
      end
   endtask

   task automatic open_cell(int w, int d, int tokens);
      req_type r;
      r = any_req(KIND_OPEN);
      r.word = WORD_W'(w);
      r.doc  = DOC_W'(d);
      r.token_count = TOKEN_W'(tokens);
      send(r);
   endtask

   task automatic draw(logic [DRAW_W-1:0] frac);
      req_type r;
      r = any_req(KIND_DRAW);
      r.random_draw = frac;
      send(r);
   endtask

   task automatic read_count(logic [KIND_W-1:0] kind, int w, int d, int t);
      req_type r;
      r = any_req(kind);
      r.word  = WORD_W'(w);
      r.doc   = DOC_W'(d);
      r.topic = TOPIC_W'(t);
      send(r);
   endtask

   function automatic int pick(int maxn);
      int s;
      s = $urandom_range(0, 4);
      if (s == 0) return 0;
      if (s == 1) return maxn - 1;
      return sampler_model.topics_eff() <= 16 ? $urandom_range(0, maxn - 1) : 0;
   endfunction

   task automatic random_phase(int n_items);
      int first, sel, w, d, tokens, n, i, nt, nw, nd;
      req_type r;
      first = sent_total;
      while (sent_total - first < n_items) begin
         nt = sampler_model.topics_eff();
         nw = sampler_model.words_eff();
         nd = sampler_model.docs_eff();
         sel = $urandom_range(0, 99);
         if (sel < 45) begin
            w = pick(nw);
            d = pick(nd);
            fill_cell_weights(w, d);
            case ($urandom_range(0, 19))
               0: tokens = 0;
               1: tokens = $urandom_range(0, 65535);
               default: tokens = $urandom_range(1, 6);
            endcase
            open_cell(w, d, tokens);
            n = $urandom_range(1, (tokens > 7) ? 8 : tokens + 1);
            for (i = 0; i < n; i++) begin
               case ($urandom_range(0, 9))
                  0: draw('0);
                  1: draw('1);
                  default: draw($urandom);
               endcase
               if ($urandom_range(0, 2) == 0)
                  read_count($urandom_range(0, 1) ? KIND_RD_DOC : KIND_RD_WORD,
                             w, d, $urandom_range(0, nt - 1));
            end
         end else if (sel < 60) begin
            r = any_req($urandom_range(0, 1) ? KIND_WR_WORD : KIND_WR_DOC);
            if ($urandom_range(0, 3) != 0) begin
               r.word  = WORD_W'($urandom_range(0, nw - 1));
               r.doc   = DOC_W'($urandom_range(0, nd - 1));
               r.topic = TOPIC_W'($urandom_range(0, nt - 1));
            end
            send(r);
         end else if (sel < 82) begin
            r = any_req($urandom_range(0, 1) ? KIND_RD_DOC : KIND_RD_WORD);
            if ($urandom_range(0, 3) != 0) begin
               r.word  = WORD_W'($urandom_range(0, nw - 1));
               r.doc   = DOC_W'($urandom_range(0, nd - 1));
               r.topic = TOPIC_W'($urandom_range(0, nt - 1));
            end
            send(r);
         end else if (sel < 90) begin
            draw($urandom);
         end else if (sel < 95 || (nw == NWORD && nd == NDOC)) begin
            send(any_req($urandom_range(0, 1) ? KIND_UNDEF_LO : KIND_UNDEF_HI));
         end else begin
            // open with an index beyond the sizes in use reads no weight
            r = any_req(KIND_OPEN);
            if (nw < NWORD) r.word = WORD_W'($urandom_range(nw, NWORD - 1));
            else r.doc = DOC_W'($urandom_range(nd, NDOC - 1));
            send(r);
         end
      end
   endtask

   initial begin
      sampler_model = new();
      calm         = 0;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // wait out the count clearing sweep
      while (busy) @(posedge clock);

      set_sizes(3, 1024, 256);
      load_weight(KIND_WR_WORD, 1023, 255, 0, 24'hFFFFFF);
      load_weight(KIND_WR_WORD, 1023, 255, 1, 24'h000001);
      load_weight(KIND_WR_WORD, 1023, 255, 2, 24'hFFFFFF);
      load_weight(KIND_WR_DOC, 1023, 255, 0, 24'hFFFFFF);
      load_weight(KIND_WR_DOC, 1023, 255, 1, 24'h000000);
      load_weight(KIND_WR_DOC, 1023, 255, 2, 24'hFFFFFF);
      open_cell(1023, 255, 3);
      draw('0);
      draw('1);
      draw($urandom);
      draw($urandom);
      read_count(KIND_RD_DOC, 0, 255, 2);
      read_count(KIND_RD_WORD, 1023, 0, 0);
      read_count(KIND_RD_DOC, 0, 255, 63);
      load_weight(KIND_WR_WORD, 1023, 0, 3, 24'h123456);
      // zero total picks the first topic
      load_weight(KIND_WR_WORD, 0, 0, 0, 0);
      load_weight(KIND_WR_WORD, 0, 0, 1, 0);
      load_weight(KIND_WR_WORD, 0, 0, 2, 0);
      open_cell(0, 255, 16'hFFFF);
      draw('1);
      open_cell(0, 255, 0);
      draw($urandom);
      send(any_req(KIND_UNDEF_LO));
      send(any_req(KIND_UNDEF_HI));

      set_sizes(64, 1024, 256);
      random_phase(90);
      set_sizes(1, 1024, 256);
      random_phase(50);
      set_sizes(0, 0, 0);
      random_phase(40);
      set_sizes(127, 2047, 511);
      random_phase(60);
      set_sizes(5, 1, 1);
      random_phase(40);
      set_sizes(16, 300, 100);
      random_phase(60);
      set_sizes(2, 1024, 255);
      random_phase(50);
      set_sizes(7, 1024, 256);
      calm = 1;
      random_phase(60);

      settle();
      if (sampler_model.errors == 0 && sampler_model.expected_rsp.size() == 0)
         $display("tb_multinomial_topic_count_sampler passed");
      else
         $display("tb_multinomial_topic_count_sampler failed");
      $finish;
   end

endmodule
